>>> hw/rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/dpcr_pkg.sv
// types, constants and helper functions of the disk pair collision block
`default_nettype none
package dpcr_pkg;

  localparam int MaxBodies = 64;
  localparam int IdxW      = 6;
  localparam int PosW      = 24;
  localparam int RadW      = 22;
  localparam int DiffW     = 25;
  localparam int RsW       = 23;
  localparam int RootW     = 25;
  localparam int DenW      = 26;
  localparam int QuoW      = 27;
  localparam int MulW      = 27;
  localparam int ProdW     = 54;
  localparam int NumW      = 52;
  localparam int RemW      = 28;
  localparam int QW        = 50;
  localparam int SqIters   = 25;
  localparam int CntW      = 6;
  localparam int SatW      = 28;

  localparam logic signed [SatW-1:0] PosMax = 28'sd8388607;
  localparam logic signed [SatW-1:0] PosMin = -28'sd8388608;

  typedef struct packed {
    logic        [IdxW-1:0] index_a;
    logic        [IdxW-1:0] index_b;
    logic signed [PosW-1:0] a_pos_x;
    logic signed [PosW-1:0] a_pos_y;
    logic        [RadW-1:0] a_radius;
    logic signed [PosW-1:0] a_vel_x;
    logic signed [PosW-1:0] a_vel_y;
    logic signed [PosW-1:0] b_pos_x;
    logic signed [PosW-1:0] b_pos_y;
    logic        [RadW-1:0] b_radius;
    logic signed [PosW-1:0] b_vel_x;
    logic signed [PosW-1:0] b_vel_y;
  } dpcr_req_t;

  typedef struct packed {
    logic signed [PosW-1:0] new_a_pos_x;
    logic signed [PosW-1:0] new_a_pos_y;
    logic signed [PosW-1:0] new_a_vel_x;
    logic signed [PosW-1:0] new_a_vel_y;
    logic signed [PosW-1:0] new_b_pos_x;
    logic signed [PosW-1:0] new_b_pos_y;
    logic signed [PosW-1:0] new_b_vel_x;
    logic signed [PosW-1:0] new_b_vel_y;
    logic                   touching;
    logic                   exchanged;
    logic                   coincident;
  } dpcr_res_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MUL_QX, ST_MUL_QY, ST_MUL_RS, ST_WR_A, ST_WR_B, ST_SQRT,
    ST_MUL_PX, ST_DIV_PX, ST_MUL_PY, ST_DIV_PY, ST_MUL_P1, ST_MUL_P2, ST_DIV_T,
    ST_MUL_EX, ST_DIV_EX, ST_MUL_EY, ST_DIV_EY, ST_OUT
  } dpcr_state_e;

  typedef enum logic {
    UNIT_DIV,
    UNIT_SQRT
  } dpcr_unit_mode_e;

  typedef struct packed {
    logic            start;
    dpcr_unit_mode_e mode;
  } dpcr_unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dpcr_unit_stat_t;

  // index reduced modulo the body count, by conditional subtraction
  function automatic int idx_mod(logic [IdxW-1:0] v, int m);
    int r;
    r = int'(v);
    for (int k = IdxW - 1; k >= 0; k--) begin
      if (r >= (m << k)) r = r - (m << k);
    end
    return r;
  endfunction

  function automatic logic signed [PosW-1:0] sat_pos(logic signed [SatW-1:0] v);
    logic signed [PosW-1:0] r;
    if (v > PosMax) r = PosMax[PosW-1:0];
    else if (v < PosMin) r = PosMin[PosW-1:0];
    else r = v[PosW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dpcr_stream_if.sv
// valid/ready stream interface
`default_nettype none
interface dpcr_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dpcr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module dpcr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hw/rtl/dpcr_divsqrt.sv
// shared restoring divider and square root unit, one result bit a cycle
`default_nettype none
module dpcr_divsqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dpcr_pkg::dpcr_unit_ctrl_t     ctrl_i,
  input  wire logic [dpcr_pkg::NumW-1:0]     num_i,
  input  wire logic [dpcr_pkg::DenW-1:0]     den_i,
  output dpcr_pkg::dpcr_unit_stat_t          stat_o,
  output logic      [dpcr_pkg::NumW-1:0]     res_o
);
  logic                          busy_q, busy_d, done_q, done_d;
  logic [dpcr_pkg::CntW-1:0]     cnt_q, cnt_d;
  dpcr_pkg::dpcr_unit_mode_e     mode_q;
  logic [dpcr_pkg::NumW-1:0]     x_q, res_q;
  logic [dpcr_pkg::RemW-1:0]     rem_q, rem_sh, trial;
  logic [dpcr_pkg::DenW-1:0]     den_q;
  logic                          ge;

  // sqrt brings in two bits, divide one
  always_comb begin
    if (mode_q == dpcr_pkg::UNIT_SQRT) begin
      rem_sh = {rem_q[dpcr_pkg::RemW-3:0], x_q[dpcr_pkg::NumW-1 -: 2]};
      trial  = {res_q[dpcr_pkg::RemW-3:0], 2'b01};
    end else begin
      rem_sh = {rem_q[dpcr_pkg::RemW-2:0], x_q[dpcr_pkg::NumW-1]};
      trial  = {2'b00, den_q};
    end
    ge = rem_sh >= trial;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = (ctrl_i.mode == dpcr_pkg::UNIT_SQRT) ?
               dpcr_pkg::CntW'(dpcr_pkg::SqIters - 1) : dpcr_pkg::CntW'(dpcr_pkg::NumW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mode_q <= ctrl_i.mode;
      x_q    <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (busy_q) begin
      x_q   <= (mode_q == dpcr_pkg::UNIT_SQRT) ? {x_q[dpcr_pkg::NumW-3:0], 2'b00} :
                                                 {x_q[dpcr_pkg::NumW-2:0], 1'b0};
      rem_q <= ge ? rem_sh - trial : rem_sh;
      res_q <= {res_q[dpcr_pkg::NumW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = res_q;
endmodule
`default_nettype wire

>>> hw/rtl/disk_pair_collision_resolve.sv
// top level: sequencer, shared multiplier and pair flag store of the disk collision block
// usage
//  - req_i carries one disk pair per request (valid/ready); res_o returns one result
//    per request, in order, with the separated positions, exchanged velocities and
//    the touching, exchanged and coincident flags
//  - one request at a time: req_i.ready is high only while the sequencer is idle
//  - the time from acceptance to the result being offered depends on the path: every
//    pair takes the square root, a push adds two divisions and an exchange three
//  - the shared divide/square root unit yields one bit a cycle: 25 steps for the
//    root and 52 for each of up to five divisions; the products come from the
//    shared 27 x 27 multiplier
//  - after reset the pair flag ram is swept to all ones, entry by entry, before
//    the first request is taken
//  - a stalled result is held in the output register until res_o.ready is high;
//    no new request is taken meanwhile
`default_nettype none
`include "assert_macros.svh"
module disk_pair_collision_resolve #(
  parameter int MAX_BODIES = dpcr_pkg::MaxBodies
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  dpcr_stream_if.sink   req_i,
  dpcr_stream_if.source res_o
);
  localparam int AW = $clog2(MAX_BODIES);

  dpcr_pkg::dpcr_state_e state_q, state_d;

  // clearing pass counter
  logic [AW-1:0] clr_q, clr_d;
  logic          started_q, started_d;

  // latched request and derived values
  dpcr_pkg::dpcr_res_t                out_q;
  logic signed [dpcr_pkg::DiffW-1:0]  dx_q, dy_q, dvx_q, dvy_q;
  logic signed [dpcr_pkg::DiffW-1:0]  dx_w, dy_w;
  logic        [dpcr_pkg::RsW-1:0]    rs_q, off_q;
  logic        [AW-1:0]               ia_q, ib_q;
  logic                               fa_q, fb_q, coinc_q, push_q, both_q, sign_q;
  logic signed [dpcr_pkg::ProdW-1:0]  acc_q, prod_q, div_src;
  logic        [dpcr_pkg::QW-1:0]     q_q, rr_w;
  logic        [dpcr_pkg::RootW-1:0]  d_q;
  logic signed [dpcr_pkg::QuoW-1:0]   px_q, t_q, ex_q, quo;

  // shared multiplier operands
  logic signed [dpcr_pkg::MulW-1:0]   mul_a, mul_b;

  // shared unit
  dpcr_pkg::dpcr_unit_ctrl_t          unit_ctrl;
  dpcr_pkg::dpcr_unit_stat_t          unit_stat;
  logic        [dpcr_pkg::NumW-1:0]   unit_num, unit_res, div_mag;
  logic        [dpcr_pkg::DenW-1:0]   unit_den;
  logic                               unit_state;

  // flag ram
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;

  logic req_acc;

  assign req_acc = req_i.valid && req_i.ready;
  assign dx_w    = {req_i.data.b_pos_x[23], req_i.data.b_pos_x}
                 - {req_i.data.a_pos_x[23], req_i.data.a_pos_x};
  assign dy_w    = {req_i.data.b_pos_y[23], req_i.data.b_pos_y}
                 - {req_i.data.a_pos_y[23], req_i.data.a_pos_y};
  assign rr_w    = dpcr_pkg::QW'(prod_q[45:0]);

  assign unit_state = (state_q == dpcr_pkg::ST_SQRT) || (state_q == dpcr_pkg::ST_DIV_PX) ||
                      (state_q == dpcr_pkg::ST_DIV_PY) || (state_q == dpcr_pkg::ST_DIV_T) ||
                      (state_q == dpcr_pkg::ST_DIV_EX) || (state_q == dpcr_pkg::ST_DIV_EY);

  // the projection sum feeds the division for t, single products feed the others
  assign div_src = (state_q == dpcr_pkg::ST_DIV_T) ? acc_q + prod_q : prod_q;
  assign div_mag = div_src[dpcr_pkg::ProdW-1] ? dpcr_pkg::NumW'(-div_src) :
                                                dpcr_pkg::NumW'(div_src);
  assign quo     = sign_q ? -$signed({1'b0, unit_res[dpcr_pkg::DenW-1:0]}) :
                             $signed({1'b0, unit_res[dpcr_pkg::DenW-1:0]});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dpcr_pkg::ST_CLEAR:  if (clr_q == AW'(MAX_BODIES - 1)) state_d = dpcr_pkg::ST_IDLE;
      dpcr_pkg::ST_IDLE:   if (req_acc) state_d = dpcr_pkg::ST_MUL_QX;
      dpcr_pkg::ST_MUL_QX: state_d = dpcr_pkg::ST_MUL_QY;
      dpcr_pkg::ST_MUL_QY: state_d = dpcr_pkg::ST_MUL_RS;
      dpcr_pkg::ST_MUL_RS: state_d = dpcr_pkg::ST_WR_A;
      dpcr_pkg::ST_WR_A:   state_d = dpcr_pkg::ST_WR_B;
      dpcr_pkg::ST_WR_B:   state_d = dpcr_pkg::ST_SQRT;
      dpcr_pkg::ST_SQRT: begin
        if (unit_stat.done) begin
          if (coinc_q) state_d = dpcr_pkg::ST_OUT;
          else if (push_q) state_d = dpcr_pkg::ST_MUL_PX;
          else if (both_q) state_d = dpcr_pkg::ST_MUL_P1;
          else state_d = dpcr_pkg::ST_OUT;
        end
      end
      dpcr_pkg::ST_MUL_PX: state_d = dpcr_pkg::ST_DIV_PX;
      dpcr_pkg::ST_DIV_PX: if (unit_stat.done) state_d = dpcr_pkg::ST_MUL_PY;
      dpcr_pkg::ST_MUL_PY: state_d = dpcr_pkg::ST_DIV_PY;
      dpcr_pkg::ST_DIV_PY: begin
        if (unit_stat.done) state_d = both_q ? dpcr_pkg::ST_MUL_P1 : dpcr_pkg::ST_OUT;
      end
      dpcr_pkg::ST_MUL_P1: state_d = dpcr_pkg::ST_MUL_P2;
      dpcr_pkg::ST_MUL_P2: state_d = dpcr_pkg::ST_DIV_T;
      dpcr_pkg::ST_DIV_T:  if (unit_stat.done) state_d = dpcr_pkg::ST_MUL_EX;
      dpcr_pkg::ST_MUL_EX: state_d = dpcr_pkg::ST_DIV_EX;
      dpcr_pkg::ST_DIV_EX: if (unit_stat.done) state_d = dpcr_pkg::ST_MUL_EY;
      dpcr_pkg::ST_MUL_EY: state_d = dpcr_pkg::ST_DIV_EY;
      dpcr_pkg::ST_DIV_EY: if (unit_stat.done) state_d = dpcr_pkg::ST_OUT;
      dpcr_pkg::ST_OUT:    if (res_o.ready) state_d = dpcr_pkg::ST_IDLE;
      default:             state_d = dpcr_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_a          = '0;
    mul_b          = '0;
    ram_we         = 1'b0;
    ram_waddr      = ia_q;
    ram_wdata      = !both_q;
    ram_raddr      = ib_q;
    unit_ctrl.start = unit_state && !started_q;
    unit_ctrl.mode  = dpcr_pkg::UNIT_DIV;
    unit_den       = {1'b0, d_q};
    unit_num       = div_mag + dpcr_pkg::NumW'(d_q >> 1);
    clr_d          = clr_q;
    started_d      = started_q;
    req_i.ready    = 1'b0;
    res_o.valid    = 1'b0;
    case (state_q)
      dpcr_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b1;
        clr_d     = clr_q + 1'b1;
      end
      dpcr_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        ram_raddr   = AW'(dpcr_pkg::idx_mod(req_i.data.index_a, MAX_BODIES));
      end
      dpcr_pkg::ST_MUL_QX: begin
        mul_a = 27'(dx_q);
        mul_b = 27'(dx_q);
      end
      dpcr_pkg::ST_MUL_QY: begin
        mul_a = 27'(dy_q);
        mul_b = 27'(dy_q);
      end
      dpcr_pkg::ST_MUL_RS: begin
        mul_a = $signed({4'b0, rs_q});
        mul_b = $signed({4'b0, rs_q});
      end
      dpcr_pkg::ST_WR_A: begin
        ram_we    = 1'b1;
        ram_wdata = !(fa_q && fb_q);
      end
      dpcr_pkg::ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = ib_q;
      end
      dpcr_pkg::ST_SQRT: begin
        unit_ctrl.mode = dpcr_pkg::UNIT_SQRT;
        unit_num       = {q_q, 2'b00};
      end
      dpcr_pkg::ST_MUL_PX: begin
        mul_a = 27'(dx_q);
        mul_b = $signed({4'b0, off_q});
      end
      dpcr_pkg::ST_MUL_PY: begin
        mul_a = 27'(dy_q);
        mul_b = $signed({4'b0, off_q});
      end
      // divisor 2d, so half the divisor is d
      dpcr_pkg::ST_DIV_PX, dpcr_pkg::ST_DIV_PY: begin
        unit_den = {d_q, 1'b0};
        unit_num = div_mag + dpcr_pkg::NumW'(d_q);
      end
      dpcr_pkg::ST_MUL_P1: begin
        mul_a = 27'(dvx_q);
        mul_b = 27'(dx_q);
      end
      dpcr_pkg::ST_MUL_P2: begin
        mul_a = 27'(dvy_q);
        mul_b = 27'(dy_q);
      end
      dpcr_pkg::ST_MUL_EX: begin
        mul_a = t_q;
        mul_b = 27'(dx_q);
      end
      dpcr_pkg::ST_MUL_EY: begin
        mul_a = t_q;
        mul_b = 27'(dy_q);
      end
      dpcr_pkg::ST_OUT: res_o.valid = 1'b1;
      default: ;
    endcase
    if (unit_ctrl.start) started_d = 1'b1;
    else if (unit_stat.done) started_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dpcr_pkg::ST_CLEAR;
      clr_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      started_q <= started_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (unit_ctrl.start) sign_q <= div_src[dpcr_pkg::ProdW-1];
    case (state_q)
      dpcr_pkg::ST_IDLE: begin
        if (req_acc) begin
          dx_q    <= dx_w;
          dy_q    <= dy_w;
          dvx_q   <= {req_i.data.b_vel_x[23], req_i.data.b_vel_x}
                   - {req_i.data.a_vel_x[23], req_i.data.a_vel_x};
          dvy_q   <= {req_i.data.b_vel_y[23], req_i.data.b_vel_y}
                   - {req_i.data.a_vel_y[23], req_i.data.a_vel_y};
          rs_q    <= {1'b0, req_i.data.a_radius} + {1'b0, req_i.data.b_radius};
          ia_q    <= AW'(dpcr_pkg::idx_mod(req_i.data.index_a, MAX_BODIES));
          ib_q    <= AW'(dpcr_pkg::idx_mod(req_i.data.index_b, MAX_BODIES));
          coinc_q <= (dx_w == '0) && (dy_w == '0);
          // unchanged values pass through unless a push or exchange follows
          out_q.new_a_pos_x <= req_i.data.a_pos_x;
          out_q.new_a_pos_y <= req_i.data.a_pos_y;
          out_q.new_a_vel_x <= req_i.data.a_vel_x;
          out_q.new_a_vel_y <= req_i.data.a_vel_y;
          out_q.new_b_pos_x <= req_i.data.b_pos_x;
          out_q.new_b_pos_y <= req_i.data.b_pos_y;
          out_q.new_b_vel_x <= req_i.data.b_vel_x;
          out_q.new_b_vel_y <= req_i.data.b_vel_y;
        end
      end
      dpcr_pkg::ST_MUL_QX: fa_q <= ram_rdata;
      dpcr_pkg::ST_MUL_QY: begin
        fb_q  <= ram_rdata;
        acc_q <= prod_q;
      end
      dpcr_pkg::ST_MUL_RS: q_q <= dpcr_pkg::QW'(acc_q + prod_q);
      dpcr_pkg::ST_WR_A: begin
        // rs squared sits in the product register here
        both_q           <= fa_q && fb_q;
        push_q           <= !coinc_q && (q_q < rr_w);
        out_q.touching   <= q_q <= rr_w;
        out_q.exchanged  <= fa_q && fb_q && !coinc_q;
        out_q.coincident <= coinc_q;
      end
      dpcr_pkg::ST_SQRT: begin
        if (unit_stat.done) begin
          d_q   <= unit_res[dpcr_pkg::RootW-1:0];
          off_q <= dpcr_pkg::RsW'({2'b00, rs_q} - unit_res[dpcr_pkg::RootW-1:0]);
        end
      end
      dpcr_pkg::ST_DIV_PX: if (unit_stat.done) px_q <= quo;
      dpcr_pkg::ST_DIV_PY: begin
        if (unit_stat.done) begin
          out_q.new_b_pos_x <= dpcr_pkg::sat_pos(28'(out_q.new_b_pos_x) + 28'(px_q));
          out_q.new_b_pos_y <= dpcr_pkg::sat_pos(28'(out_q.new_b_pos_y) + 28'(quo));
          out_q.new_a_pos_x <= dpcr_pkg::sat_pos(28'(out_q.new_a_pos_x) - 28'(px_q));
          out_q.new_a_pos_y <= dpcr_pkg::sat_pos(28'(out_q.new_a_pos_y) - 28'(quo));
        end
      end
      dpcr_pkg::ST_MUL_P2: acc_q <= prod_q;
      dpcr_pkg::ST_DIV_T:  if (unit_stat.done) t_q <= quo;
      dpcr_pkg::ST_DIV_EX: if (unit_stat.done) ex_q <= quo;
      dpcr_pkg::ST_DIV_EY: begin
        if (unit_stat.done) begin
          out_q.new_a_vel_x <= dpcr_pkg::sat_pos(28'(out_q.new_a_vel_x) + 28'(ex_q));
          out_q.new_a_vel_y <= dpcr_pkg::sat_pos(28'(out_q.new_a_vel_y) + 28'(quo));
          out_q.new_b_vel_x <= dpcr_pkg::sat_pos(28'(out_q.new_b_vel_x) - 28'(ex_q));
          out_q.new_b_vel_y <= dpcr_pkg::sat_pos(28'(out_q.new_b_vel_y) - 28'(quo));
        end
      end
      default: ;
    endcase
  end

  assign res_o.data = out_q;

  dpcr_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (unit_ctrl),
    .num_i  (unit_num),
    .den_i  (unit_den),
    .stat_o (unit_stat),
    .res_o  (unit_res)
  );

  dpcr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BODIES)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `ASSERT_IMPL(a_ready_not_busy, clk_i, rst_ni, req_i.ready, !res_o.valid)
  `ASSERT_IMPL(a_flag_excl, clk_i, rst_ni, res_o.valid, !(res_o.data.exchanged && res_o.data.coincident))
  `ASSERT_IMPL(a_start_idle, clk_i, rst_ni, unit_ctrl.start, !unit_stat.busy)
  `ASSERT_NEXT(a_ready_after_out, clk_i, rst_ni, res_o.valid && res_o.ready, req_i.ready)
endmodule
`default_nettype wire

>>> bench/tb.sv
// testbench of the disk pair collision block: directed and random pairs checked against a predictor
module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dpcr_stream_if #(.data_t(dpcr_pkg::dpcr_req_t)) req_if ();
  dpcr_stream_if #(.data_t(dpcr_pkg::dpcr_res_t)) res_if ();

  disk_pair_collision_resolve dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  // predictor state: one ready flag per body
  logic                ready_flags[dpcr_pkg::MaxBodies];
  dpcr_pkg::dpcr_res_t expected_results[$];
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;
  bit                  idle_enable = 1'b1;
  bit                  hold_off = 1'b0;
  bit                  finished = 1'b0;

  // nearest division, ties away from zero, positive divisor
  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint int_root(longint x);
    longint r;
    r = longint'($sqrt(real'(x)));
    while (r * r > x) r--;
    while ((r + 1) * (r + 1) <= x) r++;
    return r;
  endfunction

  function automatic logic signed [dpcr_pkg::PosW-1:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[dpcr_pkg::PosW-1:0];
  endfunction

  // works out the resolved pair and updates the flag store
  function automatic dpcr_pkg::dpcr_res_t resolve_pair(dpcr_pkg::dpcr_req_t p);
    dpcr_pkg::dpcr_res_t r;
    int     ia, ib;
    longint ax, ay, bx, by, avx, avy, bvx, bvy, dx, dy, q, rs, d, off, px, py;
    longint dot, t, ex, ey;
    bit     both, coinc;
    ia = p.index_a % dpcr_pkg::MaxBodies;
    ib = p.index_b % dpcr_pkg::MaxBodies;
    ax = p.a_pos_x; ay = p.a_pos_y; bx = p.b_pos_x; by = p.b_pos_y;
    avx = p.a_vel_x; avy = p.a_vel_y; bvx = p.b_vel_x; bvy = p.b_vel_y;
    dx = bx - ax;
    dy = by - ay;
    q = dx * dx + dy * dy;
    rs = longint'(p.a_radius) + longint'(p.b_radius);
    coinc = (dx == 0) && (dy == 0);
    both = ready_flags[ia] && ready_flags[ib];
    d = int_root(q);
    r.new_a_pos_x = p.a_pos_x; r.new_a_pos_y = p.a_pos_y;
    r.new_b_pos_x = p.b_pos_x; r.new_b_pos_y = p.b_pos_y;
    r.new_a_vel_x = p.a_vel_x; r.new_a_vel_y = p.a_vel_y;
    r.new_b_vel_x = p.b_vel_x; r.new_b_vel_y = p.b_vel_y;
    r.touching = (q <= rs * rs);
    r.exchanged = both && !coinc;
    r.coincident = coinc;
    // push apart by half the overlap each
    if (!coinc && q < rs * rs) begin
      off = rs - d;
      px = round_div(dx * off, 2 * d);
      py = round_div(dy * off, 2 * d);
      r.new_b_pos_x = clamp24(bx + px); r.new_b_pos_y = clamp24(by + py);
      r.new_a_pos_x = clamp24(ax - px); r.new_a_pos_y = clamp24(ay - py);
    end
    ready_flags[ia] = !both;
    ready_flags[ib] = !both;
    // swap of the velocity components along the centre line
    if (both && !coinc) begin
      dot = (bvx - avx) * dx + (bvy - avy) * dy;
      t = round_div(dot, d);
      ex = round_div(t * dx, d);
      ey = round_div(t * dy, d);
      r.new_a_vel_x = clamp24(avx + ex); r.new_a_vel_y = clamp24(avy + ey);
      r.new_b_vel_x = clamp24(bvx - ex); r.new_b_vel_y = clamp24(bvy - ey);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("result mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatch_count++;
  endtask

  // sends one request and records its expected result
  task automatic send_pair(dpcr_pkg::dpcr_req_t p);
    while (idle_enable && $urandom_range(99) < 22) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= p;
    @(posedge clk_i iff req_if.ready);
    expected_results.push_back(resolve_pair(p));
  endtask

  function automatic logic signed [dpcr_pkg::PosW-1:0] rand_coord(int spread);
    case ($urandom_range(9))
      0: return 24'sh7fffff - 24'($urandom_range(3));
      1: return 24'sh800000 + 24'($urandom_range(3));
      2: return 24'($urandom);
      default: return 24'($signed(24'($urandom_range(2 * spread))) - spread);
    endcase
  endfunction

  function automatic dpcr_pkg::dpcr_req_t rand_pair(int spread, int idx_span);
    dpcr_pkg::dpcr_req_t p;
    p.index_a = 6'($urandom_range(idx_span));
    p.index_b = ($urandom_range(15) == 0) ? p.index_a : 6'($urandom_range(idx_span));
    p.a_pos_x = rand_coord(spread); p.a_pos_y = rand_coord(spread);
    // near pairs mostly, so that pushes and exchanges are common
    if ($urandom_range(3) != 0) begin
      p.b_pos_x = 24'(p.a_pos_x + $signed(24'($urandom_range(2 * spread))) - spread);
      p.b_pos_y = 24'(p.a_pos_y + $signed(24'($urandom_range(2 * spread))) - spread);
      if ($urandom_range(20) == 0) p.b_pos_x = p.a_pos_x;
      if ($urandom_range(20) == 0) p.b_pos_y = p.a_pos_y;
    end else begin
      p.b_pos_x = rand_coord(spread); p.b_pos_y = rand_coord(spread);
    end
    p.a_radius = ($urandom_range(7) == 0) ? 22'($urandom) : 22'($urandom_range(spread));
    p.b_radius = ($urandom_range(7) == 0) ? 22'($urandom) : 22'($urandom_range(spread));
    p.a_vel_x = rand_coord(spread); p.a_vel_y = rand_coord(spread);
    p.b_vel_x = rand_coord(spread); p.b_vel_y = rand_coord(spread);
    return p;
  endfunction

  function automatic dpcr_pkg::dpcr_req_t make_pair(int ia, int ib, int ax, int ay, int ar,
                                                    int bx, int by, int br, int vel);
    dpcr_pkg::dpcr_req_t p;
    p.index_a = 6'(ia); p.index_b = 6'(ib);
    p.a_pos_x = 24'(ax); p.a_pos_y = 24'(ay); p.a_radius = 22'(ar);
    p.b_pos_x = 24'(bx); p.b_pos_y = 24'(by); p.b_radius = 22'(br);
    p.a_vel_x = 24'(vel); p.a_vel_y = 24'(-vel);
    p.b_vel_x = 24'(-vel); p.b_vel_y = 24'(vel);
    return p;
  endfunction

  // extremes, coincident centres, equal indices, saturation
  task automatic test_directed();
    send_pair(make_pair(0, 1, 0, 0, 256, 300, 0, 256, 512));
    send_pair(make_pair(0, 1, 0, 0, 256, 300, 0, 256, 512));
    send_pair(make_pair(2, 3, 100, 100, 50, 100, 100, 50, 7));
    send_pair(make_pair(4, 4, 0, 0, 10, 1000, 1000, 10, 300));
    send_pair(make_pair(4, 4, 0, 0, 10, 1000, 1000, 10, 300));
    send_pair(make_pair(63, 62, 8388607, 8388607, 4194303, -8388608, -8388608,
                        4194303, 8388607));
    send_pair(make_pair(63, 62, -8388608, -8388608, 4194303, 8388607, 8388607,
                        4194303, -8388608));
    send_pair(make_pair(5, 6, 8388600, 0, 4194303, 8388607, 0, 4194303, 1));
    send_pair(make_pair(7, 8, 0, 0, 0, 1, 0, 0, 0));
    send_pair(make_pair(7, 8, 0, 0, 0, 0, 1, 0, -8388608));
    send_pair(make_pair(9, 10, 0, 0, 100, 200, 0, 100, 8388607));
    send_pair(make_pair(11, 12, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(13, 14, -5, 3, 1, -4, 3, 0, 8388607));
    send_pair(make_pair(15, 16, 0, 0, 4194303, 3, 4, 4194303, -8388608));
    send_pair(make_pair(31, 32, 1000, -1000, 800, -1000, 1000, 800, 4096));
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k == count / 3) idle_enable = 1'b0;
      if (k == count / 2) idle_enable = 1'b1;
      send_pair(rand_pair(($urandom_range(3) == 0) ? 4000000 : 2000, 63));
    end
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_pair(rand_pair(500, 7));
    join
  endtask

  // result side: random stalls and checks
  always @(posedge clk_i) begin
    dpcr_pkg::dpcr_res_t got, want;
    if (res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.new_a_pos_x !== want.new_a_pos_x)
          report_mismatch("new_a_pos_x", got.new_a_pos_x, want.new_a_pos_x);
        if (got.new_a_pos_y !== want.new_a_pos_y)
          report_mismatch("new_a_pos_y", got.new_a_pos_y, want.new_a_pos_y);
        if (got.new_a_vel_x !== want.new_a_vel_x)
          report_mismatch("new_a_vel_x", got.new_a_vel_x, want.new_a_vel_x);
        if (got.new_a_vel_y !== want.new_a_vel_y)
          report_mismatch("new_a_vel_y", got.new_a_vel_y, want.new_a_vel_y);
        if (got.new_b_pos_x !== want.new_b_pos_x)
          report_mismatch("new_b_pos_x", got.new_b_pos_x, want.new_b_pos_x);
        if (got.new_b_pos_y !== want.new_b_pos_y)
          report_mismatch("new_b_pos_y", got.new_b_pos_y, want.new_b_pos_y);
        if (got.new_b_vel_x !== want.new_b_vel_x)
          report_mismatch("new_b_vel_x", got.new_b_vel_x, want.new_b_vel_x);
        if (got.new_b_vel_y !== want.new_b_vel_y)
          report_mismatch("new_b_vel_y", got.new_b_vel_y, want.new_b_vel_y);
        if (got.touching !== want.touching)
          report_mismatch("touching", got.touching, want.touching);
        if (got.exchanged !== want.exchanged)
          report_mismatch("exchanged", got.exchanged, want.exchanged);
        if (got.coincident !== want.coincident)
          report_mismatch("coincident", got.coincident, want.coincident);
      end
    end
    res_if.ready <= !hold_off && (!idle_enable || $urandom_range(99) >= 22);
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || hold_off)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000 && !finished) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
    for (int k = 0; k < dpcr_pkg::MaxBodies; k++) ready_flags[k] = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(1620);
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    finished = 1'b1;
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/dpcr_pkg.sv
hw/rtl/dpcr_stream_if.sv
hw/rtl/dpcr_ram.sv
hw/rtl/dpcr_divsqrt.sv
hw/rtl/disk_pair_collision_resolve.sv
bench/tb.sv
